// ===== rtl/scfd_pkg.sv =====
package scfd_pkg;

	localparam int unsigned FOLD_BYTES = 32;
	localparam int unsigned POS_W      = $clog2(FOLD_BYTES);
	localparam int unsigned FOLD_WORDS = 4;
	localparam int unsigned NUM_WORDS  = FOLD_WORDS + 1;
	localparam int unsigned IDX_W      = 3;
	localparam int unsigned WORD_W     = 64;

	localparam logic [IDX_W-1:0] CRC_IDX  = IDX_W'(0);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WORDS - 1);

	localparam logic [31:0] CRC_POLY   = 32'h82F6_3B78;
	localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

	typedef logic [FOLD_BYTES-1:0][7:0] fold_t;

	typedef struct packed {
		logic        load;
		logic [31:0] crc;
		fold_t       fold;
	} snap_t;

	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/scfd_in_if.sv =====
interface scfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       end_of_snapshot;

	modport source (output valid, data_byte, byte_valid, end_of_snapshot, input ready);
	modport sink (input valid, data_byte, byte_valid, end_of_snapshot, output ready);
endinterface

// ===== rtl/scfd_out_if.sv =====
interface scfd_out_if;
	logic                           valid;
	logic                           ready;
	logic [scfd_pkg::WORD_W-1:0]    result_word;
	logic [scfd_pkg::IDX_W-1:0]     word_index;
	logic                           last_word;

	modport source (output valid, result_word, word_index, last_word, input ready);
	modport sink (input valid, result_word, word_index, last_word, output ready);
endinterface

// ===== rtl/snapshot_crc32c_and_fold_digest.sv =====
// Snapshot digest: one snapshot byte per input beat, accepted every cycle unless a held end
// beat stalls stage 1. Each valid byte updates a reflected CRC32C (poly 0x82F63B78, preset
// all ones) and is XORed into fold slot n mod 32; bytes with byte_valid low are skipped. A
// beat with end_of_snapshot high (its byte absorbed first) produces five output beats: the
// inverted CRC in word 0, then the 32-byte fold as words 1 to 4, slot 0 in the low byte,
// last_word on word 4. State then returns to reset. Input beats pass a stage 1 register;
// an end beat then loads the single result buffer. Its five words leave one per cycle
// while ready is high; a later end beat waits until the prior run's last word is taken.
module snapshot_crc32c_and_fold_digest (
	input  logic         clk,
	input  logic         arst_n,
	scfd_in_if.sink      snap_in,
	scfd_out_if.source   digest_out
);

	scfd_pkg::snap_t snap;
	logic            buf_free;

	scfd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.snap_in  (snap_in),
		.buf_free (buf_free),
		.snap     (snap)
	);

	scfd_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap       (snap),
		.buf_free   (buf_free),
		.digest_out (digest_out)
	);

endmodule

// ===== rtl/scfd_core.sv =====
module scfd_core (
	input  logic              clk,
	input  logic              arst_n,
	scfd_in_if.sink           snap_in,
	input  logic              buf_free,
	output scfd_pkg::snap_t   snap
);

	logic       vld_s1;
	logic [7:0] data_s1;
	logic       bv_s1;
	logic       end_s1;

	logic [31:0]                   crc_q;
	scfd_pkg::fold_t               fold_q;
	logic [scfd_pkg::POS_W-1:0]    pos_q;

	logic [31:0]                   crc_d;
	scfd_pkg::fold_t               fold_d;
	logic [scfd_pkg::POS_W-1:0]    pos_d;
	logic                          commit;
	logic                          take;

	assign commit        = vld_s1 && (!end_s1 || buf_free);
	assign take          = commit && bv_s1;
	assign snap_in.ready = !vld_s1 || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (snap_in.ready) begin
			vld_s1 <= snap_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_in.ready && snap_in.valid) begin
			data_s1 <= snap_in.data_byte;
			bv_s1   <= snap_in.byte_valid;
			end_s1  <= snap_in.end_of_snapshot;
		end
	end

	always_comb begin
		crc_d = take ? scfd_pkg::crc32c_byte(crc_q, data_s1) : crc_q;
		for (int i = 0; i < scfd_pkg::FOLD_BYTES; i++) begin
			fold_d[i] = fold_q[i] ^ ((take && pos_q == scfd_pkg::POS_W'(i)) ? data_s1 : 8'h00);
		end
		if (!take) begin
			pos_d = pos_q;
		end else if (pos_q == scfd_pkg::POS_W'(scfd_pkg::FOLD_BYTES - 1)) begin
			pos_d = '0;
		end else begin
			pos_d = pos_q + scfd_pkg::POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= scfd_pkg::CRC_PRESET;
			fold_q <= '0;
			pos_q  <= '0;
		end else if (commit && end_s1) begin
			crc_q  <= scfd_pkg::CRC_PRESET;
			fold_q <= '0;
			pos_q  <= '0;
		end else if (commit) begin
			crc_q  <= crc_d;
			fold_q <= fold_d;
			pos_q  <= pos_d;
		end
	end

	assign snap.load = commit && end_s1;
	assign snap.crc  = crc_d ^ scfd_pkg::CRC_PRESET;
	assign snap.fold = fold_d;

	a_reset_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && end_s1) |=> (crc_q == scfd_pkg::CRC_PRESET && pos_q == '0 && fold_q == '0))
		else $error("state not cleared after end beat");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !commit) |=> (vld_s1 && $stable(data_s1) && $stable(end_s1) && $stable(bv_s1)))
		else $error("stalled stage 1 beat lost");

	a_skip_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && !bv_s1 && !end_s1) |=> ($stable(crc_q) && $stable(pos_q) && $stable(fold_q)))
		else $error("skipped byte changed state");

endmodule

// ===== rtl/scfd_out.sv =====
module scfd_out (
	input  logic              clk,
	input  logic              arst_n,
	input  scfd_pkg::snap_t   snap,
	output logic              buf_free,
	scfd_out_if.source        digest_out
);

	logic                          busy_q;
	logic [scfd_pkg::IDX_W-1:0]    idx_q;
	logic [31:0]                   crc_q;
	scfd_pkg::fold_t               fold_q;
	logic [scfd_pkg::WORD_W-1:0]   words [scfd_pkg::NUM_WORDS];
	logic                          beat_done;

	assign beat_done = busy_q && digest_out.ready;
	assign buf_free  = !busy_q || (digest_out.ready && idx_q == scfd_pkg::LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= scfd_pkg::CRC_IDX;
		end else if (snap.load) begin
			busy_q <= 1'b1;
			idx_q  <= scfd_pkg::CRC_IDX;
		end else if (beat_done) begin
			if (idx_q == scfd_pkg::LAST_IDX) begin
				busy_q <= 1'b0;
				idx_q  <= scfd_pkg::CRC_IDX;
			end else begin
				idx_q <= idx_q + scfd_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap.load) begin
			crc_q  <= snap.crc;
			fold_q <= snap.fold;
		end
	end

	always_comb begin
		words[0] = {32'h0, crc_q};
		for (int w = 0; w < scfd_pkg::FOLD_WORDS; w++) begin
			words[w + 1] = '0;
			for (int s = 0; s < 8; s++) begin
				if (w * 8 + s < scfd_pkg::FOLD_BYTES) begin
					words[w + 1][8*s +: 8] = fold_q[w * 8 + s];
				end
			end
		end
	end

	assign digest_out.valid       = busy_q;
	assign digest_out.result_word = words[idx_q];
	assign digest_out.word_index  = idx_q;
	assign digest_out.last_word   = (idx_q == scfd_pkg::LAST_IDX);

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		snap.load |-> buf_free)
		else $error("snapshot loaded over pending words");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= scfd_pkg::LAST_IDX)
		else $error("word index out of range");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(beat_done && idx_q != scfd_pkg::LAST_IDX && !snap.load) |=>
		(busy_q && idx_q == $past(idx_q) + scfd_pkg::IDX_W'(1)))
		else $error("word sequence skipped");

endmodule
